[hw/rtl/cfsp_pkg.sv]
package cfsp_pkg;

  // Fixed-point layout: unit-cube values are signed Q2.30
  localparam int QI     = 30;
  localparam int NDIV   = 31;  // quotient bits of the normalizing divide
  localparam int NSQ    = 31;  // root bits of the square root
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [30:0] Q_ONE      = 31'h4000_0000;
  localparam logic [30:0] DIV3_RECIP = 31'd1431655766;  // ceil(2^32 / 3)

  // Register map
  localparam logic [0:0] REG_FACE_SIZE     = 1'b0;
  localparam logic [0:0] REG_SPHERE_RADIUS = 1'b1;
  localparam logic [31:0] FACE_SIZE_RST     = 32'd67108864;
  localparam logic [31:0] SPHERE_RADIUS_RST = 32'd419430400;

  // Face codes; 6 and 7 are invalid
  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  typedef logic signed [31:0] qv_t;

  // Entry passed from the front to the back
  typedef struct packed {
    logic [2:0][31:0] axis;
    logic [33:0]      scale;
    logic             bad;
  } qent_t;

endpackage

[hw/rtl/cfsp_if.sv]
interface cfsp_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        pos_x;
  logic [31:0]        pos_z;
  logic signed [31:0] height;
  logic [2:0]         face;

  modport source (output valid, pos_x, pos_z, height, face, input ready);
  modport sink (input valid, pos_x, pos_z, height, face, output ready);
endinterface

interface cfsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] sphere_x;
  logic signed [39:0] sphere_y;
  logic signed [39:0] sphere_z;
  logic               bad_face;

  modport source (output valid, sphere_x, sphere_y, sphere_z, bad_face, input ready);
  modport sink (input valid, sphere_x, sphere_y, sphere_z, bad_face, output ready);
endinterface

[hw/rtl/cfsp_front.sv]
module cfsp_front (
  input  logic             clk,
  input  logic             rst_n,
  cfsp_in_if.sink          in_ch,
  input  logic [31:0]      face_size,
  input  logic [31:0]      sphere_radius,
  output logic             push_valid,
  output cfsp_pkg::qent_t  push_data,
  input  logic             push_ready
);
  import cfsp_pkg::*;

  // One divider lane: remainder, quotient so far, clamp and sign flags
  typedef struct packed {
    logic [32:0] rem;
    logic [30:0] quo;
    logic        sat;
    logic        neg;
  } dlane_t;

  typedef struct packed {
    dlane_t      lx;
    dlane_t      lz;
    logic [31:0] height;
    logic [2:0]  face;
  } fstage_t;

  // |2p - s| as dividend, sign and clamp for p >= s
  function automatic dlane_t div_init(logic [31:0] p, logic [31:0] s);
    logic [32:0] twice;
    dlane_t      d;
    twice = {p, 1'b0};
    d.quo = '0;
    d.sat = (p >= s);
    if (twice >= {1'b0, s}) begin
      d.rem = twice - {1'b0, s};
      d.neg = 1'b0;
    end else begin
      d.rem = {1'b0, s} - twice;
      d.neg = 1'b1;
    end
    return d;
  endfunction

  // One restoring quotient bit; the top bit is taken without a shift
  function automatic dlane_t div_step(dlane_t d, logic [31:0] s, logic first);
    logic [32:0] sh;
    logic        ge;
    dlane_t      n;
    sh    = first ? d.rem : {d.rem[31:0], 1'b0};
    ge    = (sh >= {1'b0, s});
    n     = d;
    n.rem = ge ? (sh - {1'b0, s}) : sh;
    n.quo = {d.quo[29:0], ge};
    return n;
  endfunction

  function automatic qv_t div_result(dlane_t d);
    logic [30:0] mag;
    mag = d.sat ? Q_ONE : d.quo;
    return d.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  fstage_t           st_r [0:NDIV];
  fstage_t           st_nxt [0:NDIV];
  qent_t             out_r;
  qent_t             out_nxt;
  logic [NDIV+1:0]   vld_r;
  logic              f_en;

  assign f_en        = !vld_r[NDIV+1] || push_ready;
  assign in_ch.ready = f_en;
  assign push_valid  = vld_r[NDIV+1];
  assign push_data   = out_r;

  // Entry stage and divider stages
  always_comb begin
    st_nxt[0].lx     = div_init(in_ch.pos_x, face_size);
    st_nxt[0].lz     = div_init(in_ch.pos_z, face_size);
    st_nxt[0].height = in_ch.height;
    st_nxt[0].face   = in_ch.face;
    for (int k = 0; k < NDIV; k++) begin
      st_nxt[k+1]    = st_r[k];
      st_nxt[k+1].lx = div_step(st_r[k].lx, face_size, k == 0);
      st_nxt[k+1].lz = div_step(st_r[k].lz, face_size, k == 0);
    end
  end

  // Face classification: axis permutation, scale, invalid flag
  always_comb begin
    qv_t a;
    qv_t b;
    qv_t x;
    qv_t y;
    qv_t z;
    a = div_result(st_r[NDIV].lx);
    b = div_result(st_r[NDIV].lz);
    x = '0;
    y = '0;
    z = '0;
    out_nxt.bad = 1'b0;
    unique case (st_r[NDIV].face)
      FACE_PX: begin x = $signed({1'b0, Q_ONE});  y = -b; z = -a; end
      FACE_NX: begin x = -$signed({1'b0, Q_ONE}); y = -b; z = a;  end
      FACE_PY: begin x = -b; y = $signed({1'b0, Q_ONE});  z = a;  end
      FACE_NY: begin x = b;  y = -$signed({1'b0, Q_ONE}); z = a;  end
      FACE_PZ: begin x = -a; y = -b; z = -$signed({1'b0, Q_ONE}); end
      FACE_NZ: begin x = a;  y = -b; z = $signed({1'b0, Q_ONE});  end
      default: out_nxt.bad = 1'b1;
    endcase
    out_nxt.axis[0] = x;
    out_nxt.axis[1] = y;
    out_nxt.axis[2] = z;
    out_nxt.scale   = {2'b00, sphere_radius}
                    + {{2{st_r[NDIV].height[31]}}, st_r[NDIV].height};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (f_en) begin
      vld_r <= {vld_r[NDIV:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      for (int k = 0; k <= NDIV; k++) begin
        st_r[k] <= st_nxt[k];
      end
      out_r <= out_nxt;
    end
  end

endmodule

[hw/rtl/cfsp_queue.sv]
module cfsp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  cfsp_pkg::qent_t  push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output cfsp_pkg::qent_t  pop_data,
  input  logic             pop_ready
);
  import cfsp_pkg::*;

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QPTR_W:0]   cnt_r;
  logic [QPTR_W:0]   cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/cfsp_back.sv]
module cfsp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  cfsp_pkg::qent_t  pop_data,
  output logic             pop_ready,
  cfsp_out_if.source       out_ch
);
  import cfsp_pkg::*;

  // Stage positions
  localparam int ST_E = 4;              // polynomial, first root stage
  localparam int ST_F = ST_E + NSQ + 1; // axis times root
  localparam int ST_G = ST_F + 1;       // scale product
  localparam int ST_H = ST_G + 1;       // output register
  localparam int NB   = ST_H + 1;

  localparam int NEXT1 [3] = '{1, 2, 0};
  localparam int NEXT2 [3] = '{2, 0, 1};

  function automatic logic [30:0] mag31(logic [31:0] a);
    logic [31:0] n;
    n = -a;
    return a[31] ? n[30:0] : a[30:0];
  endfunction

  qent_t             e_r [0:ST_G];
  logic [NB-1:0]     bv_r;
  logic              b_en;

  logic [2:0][30:0]  sqb_r, sqc_r, sqd_r;
  logic [2:0][30:0]  ppc_r, td_r;
  logic [2:0][30:0]  sq_nxt, pp_nxt, t_nxt, poly_nxt;
  logic [2:0][34:0]  rem_r  [0:NSQ];
  logic [2:0][30:0]  root_r [0:NSQ];
  logic [2:0][30:0]  pol_r  [0:NSQ];
  logic [2:0][34:0]  rem_nxt  [1:NSQ];
  logic [2:0][30:0]  root_nxt [1:NSQ];
  logic [2:0][30:0]  mf_r, mf_nxt;
  logic [2:0][34:0]  pg_r, pg_nxt;
  logic [2:0]        negg_r, negg_nxt;
  logic [2:0][39:0]  res_r, res_nxt;
  logic              bad_r;

  assign b_en      = !bv_r[NB-1] || out_ch.ready;
  assign pop_ready = b_en;

  assign out_ch.valid    = bv_r[NB-1];
  assign out_ch.sphere_x = res_r[0];
  assign out_ch.sphere_y = res_r[1];
  assign out_ch.sphere_z = res_r[2];
  assign out_ch.bad_face = bad_r;

  // Squares, cross products, divide by three, polynomial
  always_comb begin
    logic [61:0] p;
    logic [31:0] acc;
    for (int k = 0; k < 3; k++) begin
      p           = 62'(mag31(e_r[0].axis[k])) * 62'(mag31(e_r[0].axis[k]));
      sq_nxt[k]   = p[60:30];
      p           = 62'(sqb_r[NEXT1[k]]) * 62'(sqb_r[NEXT2[k]]);
      pp_nxt[k]   = p[60:30];
      p           = 62'(ppc_r[k]) * 62'(DIV3_RECIP);
      t_nxt[k]    = {1'b0, p[61:32]};
      acc         = {1'b0, Q_ONE} - {2'b00, sqd_r[NEXT1[k]][30:1]}
                  - {2'b00, sqd_r[NEXT2[k]][30:1]} + {1'b0, td_r[k]};
      poly_nxt[k] = acc[30:0];
    end
  end

  // Square root of poly << 30, one root bit per stage
  always_comb begin
    logic [61:0] v;
    logic [34:0] base;
    logic [34:0] trial;
    for (int j = 0; j < NSQ; j++) begin
      for (int k = 0; k < 3; k++) begin
        v     = {1'b0, pol_r[j][k], 30'b0};
        base  = {rem_r[j][k][32:0], v[61-2*j -: 2]};
        trial = {2'b00, root_r[j][k], 2'b01};
        if (base >= trial) begin
          rem_nxt[j+1][k]  = base - trial;
          root_nxt[j+1][k] = {root_r[j][k][29:0], 1'b1};
        end else begin
          rem_nxt[j+1][k]  = base;
          root_nxt[j+1][k] = {root_r[j][k][29:0], 1'b0};
        end
      end
    end
  end

  // Axis times root, then times scale; magnitudes with separate sign
  always_comb begin
    logic [61:0] p;
    logic [64:0] q;
    logic [33:0] smag;
    logic [39:0] m40;
    smag = e_r[ST_F].scale[33] ? -e_r[ST_F].scale : e_r[ST_F].scale;
    for (int k = 0; k < 3; k++) begin
      p           = 62'(mag31(e_r[ST_F-1].axis[k])) * 62'(root_r[NSQ][k]);
      mf_nxt[k]   = p[60:30];
      q           = 65'(smag) * 65'(mf_r[k]);
      pg_nxt[k]   = q[64:30];
      negg_nxt[k] = e_r[ST_F].scale[33] ^ e_r[ST_F].axis[k][31];
      // Magnitude stays below 2^34, so the 40-bit range is never exceeded
      m40         = {5'b0, pg_r[k]};
      if (e_r[ST_G].bad) begin
        res_nxt[k] = '0;
      end else begin
        res_nxt[k] = negg_r[k] ? -m40 : m40;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (b_en) begin
      bv_r <= {bv_r[NB-2:0], pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      e_r[0] <= pop_data;
      for (int s = 1; s <= ST_G; s++) begin
        e_r[s] <= e_r[s-1];
      end
      sqb_r <= sq_nxt;
      sqc_r <= sqb_r;
      sqd_r <= sqc_r;
      ppc_r <= pp_nxt;
      td_r  <= t_nxt;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      pol_r[0]  <= poly_nxt;
      for (int j = 1; j <= NSQ; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        pol_r[j]  <= pol_r[j-1];
      end
      mf_r   <= mf_nxt;
      pg_r   <= pg_nxt;
      negg_r <= negg_nxt;
      res_r  <= res_nxt;
      bad_r  <= e_r[ST_G].bad;
    end
  end

endmodule

[hw/rtl/cube_face_to_sphere_point_unit.sv]
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    pos_x, pos_z, height, face
// out_ch   out  valid/ready    sphere_x, sphere_y, sphere_z, bad_face
// cfg      in   APB, 2 regs    face_size @0x0, sphere_radius @0x4
//
// One transaction per cycle sustained while out_ch is ready. The front holds
// an entry register, a 31-stage normalizing divider and a classify register;
// the queue follows it, then the back with its 31-stage root.
// Reset is synchronous, active low; it empties all stages and the queue.
// An output stall holds the back; the 4-entry queue lets the front run on
// until it fills.
module cube_face_to_sphere_point_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  cfsp_in_if.sink                      in_ch,
  cfsp_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfsp_pkg::CFG_AW-1:0]  paddr,
  input  logic [cfsp_pkg::CFG_DW-1:0]  pwdata,
  output logic [cfsp_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import cfsp_pkg::*;

  logic [31:0] face_size_r;
  logic [31:0] sphere_radius_r;
  logic [0:0]  reg_idx;
  logic        wr_en;

  logic        push_valid;
  logic        push_ready;
  qent_t       push_data;
  logic        pop_valid;
  logic        pop_ready;
  qent_t       pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  // Register read
  always_comb begin
    unique case (reg_idx)
      REG_FACE_SIZE:     prdata = face_size_r;
      REG_SPHERE_RADIUS: prdata = sphere_radius_r;
      default:           prdata = '0;
    endcase
  end

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_size_r     <= FACE_SIZE_RST;
      sphere_radius_r <= SPHERE_RADIUS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FACE_SIZE:     face_size_r     <= pwdata;
        REG_SPHERE_RADIUS: sphere_radius_r <= pwdata;
        default:           ;
      endcase
    end
  end

  cfsp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .face_size     (face_size_r),
    .sphere_radius (sphere_radius_r),
    .push_valid    (push_valid),
    .push_data     (push_data),
    .push_ready    (push_ready)
  );

  cfsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  cfsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import cfsp_pkg::*;

  localparam logic signed [63:0] UNIT   = 64'sd1 << 30;
  localparam logic signed [63:0] OUT_HI = (64'sd1 <<< 39) - 1;
  localparam logic signed [63:0] OUT_LO = -(64'sd1 <<< 39);
  localparam int LAT = 80;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_z;
    logic [31:0] height;
    logic [2:0]  face;
  } point_t;

  typedef struct packed {
    logic [39:0] sx;
    logic [39:0] sy;
    logic [39:0] sz;
    logic        bad;
  } sph_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  cfsp_in_if  in_ch ();
  cfsp_out_if out_ch ();

  cube_face_to_sphere_point_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [31:0] face_len = FACE_SIZE_RST;
  logic [31:0] radius = SPHERE_RADIUS_RST;

  point_t pending_pts[$];
  sph_t   expected_pts[$];
  int src_idle = 32, snk_idle = 59;
  int n_sent = 0, n_seen = 0, n_bad = 0, errors = 0;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2p/s - 1 in Q2.30, clamped at +1
  function automatic logic signed [63:0] to_unit(input logic [63:0] p, input logic [63:0] s);
    logic [63:0] tw;
    tw = p << 1;
    if (p >= s) return UNIT;
    if (tw >= s) return ((tw - s) << 30) / s;
    return -$signed(((s - tw) << 30) / s);
  endfunction

  function automatic logic signed [63:0] warp_axis(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input logic signed [63:0] c);
    logic [63:0] b2, c2, poly, rt, m;
    b2 = (mag(b) * mag(b)) >> 30;
    c2 = (mag(c) * mag(c)) >> 30;
    poly = UNIT - (b2 >> 1) - (c2 >> 1) + ((b2 * c2) >> 30) / 3;
    rt = floor_root(poly << 30);
    m = (mag(a) * rt) >> 30;
    return a < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [39:0] scaled(input logic signed [63:0] s,
                                         input logic signed [63:0] r);
    logic [63:0] m;
    logic signed [63:0] v;
    m = (mag(s) * mag(r)) >> 30;
    if (m > OUT_HI + 1) m = OUT_HI + 1;
    v = ((s < 0) != (r < 0)) ? -$signed(m) : $signed(m);
    if (v > OUT_HI) v = OUT_HI;
    if (v < OUT_LO) v = OUT_LO;
    return v[39:0];
  endfunction

  function automatic sph_t project_point(input point_t p);
    logic signed [63:0] a, b, x, y, z, s;
    sph_t o;
    a = to_unit(p.pos_x, face_len);
    b = to_unit(p.pos_z, face_len);
    o = '0;
    case (p.face)
      FACE_PX: begin x = UNIT;  y = -b;    z = -a;    end
      FACE_NX: begin x = -UNIT; y = -b;    z = a;     end
      FACE_PY: begin x = -b;    y = UNIT;  z = a;     end
      FACE_NY: begin x = b;     y = -UNIT; z = a;     end
      FACE_PZ: begin x = -a;    y = -b;    z = -UNIT; end
      FACE_NZ: begin x = a;     y = -b;    z = UNIT;  end
      default: begin
        o.bad = 1'b1;
        return o;
      end
    endcase
    s = $signed({32'd0, radius}) + $signed({{32{p.height[31]}}, p.height});
    o.sx = scaled(s, warp_axis(x, y, z));
    o.sy = scaled(s, warp_axis(y, z, x));
    o.sz = scaled(s, warp_axis(z, x, y));
    return o;
  endfunction

  // driver: one transaction per handshake, changes at falling edge
  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_z = '0;
    in_ch.height = '0;
    in_ch.face = '0;
    out_ch.ready = 1'b0;
  end

  logic hold_src = 1'b1;
  logic in_taken = 1'b0;

  // input side: record each accepted transaction at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_pts.push_back(project_point(
        '{in_ch.pos_x, in_ch.pos_z, in_ch.height, in_ch.face}));
      n_sent++;
    end
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin
    point_t p;
    if (!in_ch.valid || in_taken) begin
      if (!hold_src && pending_pts.size() > 0 && $urandom_range(99) >= src_idle) begin
        p = pending_pts.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.pos_x <= p.pos_x;
        in_ch.pos_z <= p.pos_z;
        in_ch.height <= p.height;
        in_ch.face <= p.face;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle);
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    sph_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pts.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h bad=%b", $time,
                 out_ch.sphere_x, out_ch.sphere_y, out_ch.sphere_z, out_ch.bad_face);
        errors++;
      end else begin
        want = expected_pts.pop_front();
        n_seen++;
        if (want.bad) n_bad++;
        if (out_ch.sphere_x !== want.sx) begin
          $display("%0t: sphere_x expected %h actual %h", $time, want.sx, out_ch.sphere_x);
          errors++;
        end
        if (out_ch.sphere_y !== want.sy) begin
          $display("%0t: sphere_y expected %h actual %h", $time, want.sy, out_ch.sphere_y);
          errors++;
        end
        if (out_ch.sphere_z !== want.sz) begin
          $display("%0t: sphere_z expected %h actual %h", $time, want.sz, out_ch.sphere_z);
          errors++;
        end
        if (out_ch.bad_face !== want.bad) begin
          $display("%0t: bad_face expected %b actual %b", $time, want.bad, out_ch.bad_face);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(input logic [CFG_AW-1:0] addr, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == 3'd0) face_len = val;
    else if (addr == 3'd4) radius = val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // let everything queued drain out; checked at the rising edge where
  // the driver's outputs are settled
  task automatic drain();
    while (pending_pts.size() > 0 || in_ch.valid || expected_pts.size() > 0) @(posedge clk);
    repeat (LAT) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pos(input logic [31:0] s);
    case ($urandom_range(9))
      0: return $urandom();
      1: return s;
      2: return 32'd0;
      3: return s >> 1;
      default: return s == 0 ? 0 : $urandom_range(s - 1, 0);
    endcase
  endfunction

  function automatic logic [31:0] rand_height();
    case ($urandom_range(9))
      0: return $urandom();
      1: return -radius - $urandom_range(65536 * 100, 0);
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      default: return $signed($urandom_range(65536 * 400, 0)) - 65536 * 200;
    endcase
  endfunction

  task automatic push_random(input int n);
    point_t p;
    for (int i = 0; i < n; i++) begin
      p.pos_x = rand_pos(face_len);
      p.pos_z = rand_pos(face_len);
      p.height = rand_height();
      p.face = ($urandom_range(15) == 0) ? $urandom_range(7, 6) : $urandom_range(5);
      pending_pts.push_back(p);
    end
  endtask

  initial begin
    logic [31:0] sizes[4] = '{32'h0001_0000, 32'hffff_ffff, 32'h0040_0000, 32'h1234_5678};
    logic [31:0] radii[4] = '{32'hffff_ffff, 32'h0001_0000, 32'h0100_0000, 32'h7fff_0000};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    hold_src = 1'b0;

    // directed: every face, both extremes, edges of the face, big heights
    for (int f = 0; f < 8; f++) begin
      pending_pts.push_back('{32'd0, 32'd0, 32'd0, 3'(f)});
      pending_pts.push_back('{face_len, 32'hffff_ffff, 32'h0010_0000, 3'(f)});
    end
    pending_pts.push_back('{face_len >> 1, face_len >> 1, 32'h7fff_ffff, FACE_PX});
    pending_pts.push_back('{32'h0123_4567, 32'h0234_5678, 32'h8000_0000, FACE_NY});
    pending_pts.push_back('{32'h0100_0000, 32'h0300_0000, -radius - 32'h0001_0000, FACE_PZ});
    pending_pts.push_back('{32'hffff_ffff, 32'd0, 32'hffff_ffff, FACE_NZ});
    push_random(500);
    drain();
    reg_write(3'd0, sizes[0]);
    reg_write(3'd4, radii[0]);
    push_random(300);
    drain();
    src_idle = 59;
    snk_idle = 32;
    for (int k = 1; k < 4; k++) begin
      reg_write(3'd0, sizes[k]);
      reg_write(3'd4, radii[k]);
      push_random(150);
      drain();
    end
    src_idle = 0;
    snk_idle = 0;
    reg_write(3'd0, FACE_SIZE_RST);
    reg_write(3'd4, SPHERE_RADIUS_RST);
    push_random(450);
    drain();

    $display("Covered %0d points (%0d invalid-face) over 6 register settings,", n_seen, n_bad);
    $display("with random stalls on both channels and a full drain between settings.");
    if (errors == 0 && expected_pts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[cube_face_to_sphere_point_unit.f]
hw/rtl/cfsp_pkg.sv
hw/rtl/cfsp_if.sv
hw/rtl/cfsp_front.sv
hw/rtl/cfsp_queue.sv
hw/rtl/cfsp_back.sv
hw/rtl/cube_face_to_sphere_point_unit.sv
tb/tb_top.sv
